// File: rtl/core/dssm_pkg.sv
// ============================================================================
// dssm_pkg - shared definitions for the dual stack shared memory core
// Default sizes, channel field widths, register reset value, operation,
// stack select and status codes, controller state type and command bundle.
// ============================================================================
package dssm_pkg;

  // default sizing of the shared store
  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths
  localparam int CAP_W    = 9;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // stack select codes
  localparam logic SEL_LOWER = 1'b0;
  localparam logic SEL_UPPER = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic {
    CTL_IDLE,
    CTL_RESP
  } ctl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;    // take the input transaction, update pointers, access store
    logic load_out;  // move the pending result into the output register
  } ctl_cmd_t;

endpackage

// File: rtl/core/dssm_if.sv
// ============================================================================
// dssm_if - channel interfaces of the dual stack shared memory core
// Request, result and configuration channels with valid/ready handshake.
// ============================================================================
interface dssm_in_if import dssm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic             stack_select;
  logic [VAL_W-1:0] push_value;

  modport source (output valid, operation, stack_select, push_value, input ready);
  modport sink   (input valid, operation, stack_select, push_value, output ready);
endinterface

interface dssm_out_if import dssm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VAL_W-1:0]    popped_value;

  modport source (output valid, status, popped_value, input ready);
  modport sink   (input valid, status, popped_value, output ready);
endinterface

interface dssm_cfg_if import dssm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/dssm_ram.sv
// ============================================================================
// dssm_ram - single port store
// One write or one read per cycle, read data registered.
// ============================================================================
module dssm_ram #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 8
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic                  we,
  input  logic [AW-1:0]         addr,
  input  logic [DATA_WIDTH-1:0] wdata,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en && !we) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/dssm_ctrl.sv
// ============================================================================
// dssm_ctrl - transaction sequencer
// Accepts one request, then hands its result to the output register.
// ============================================================================
module dssm_ctrl import dssm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CTL_IDLE: begin
        if (in_valid) begin
          state_nxt = CTL_RESP;
        end
      end
      CTL_RESP: begin
        if (out_free) begin
          state_nxt = CTL_IDLE;
        end
      end
      default: state_nxt = CTL_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      CTL_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      CTL_RESP: begin
        cmd.load_out = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CTL_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/dssm_datapath.sv
// ============================================================================
// dssm_datapath - stack pointers, store access and result register
// Holds both stack counts and the capacity register, addresses the store
// and builds the result of each transaction.
// ============================================================================
module dssm_datapath import dssm_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_cmd_t            cmd,
  input  logic                in_operation,
  input  logic                in_stack_select,
  input  logic [VAL_W-1:0]    in_push_value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAP_W-1:0]    cfg_data,
  output logic [STATUS_W-1:0] out_status,
  output logic [VAL_W-1:0]    out_popped_value
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (CW > CAP_W) ? CW : CAP_W;
  localparam int MW = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;

  logic [CAP_W-1:0]      cap_r;
  logic [CW-1:0]         lower_r, lower_nxt;
  logic [CW-1:0]         upper_r, upper_nxt;
  logic [STATUS_W-1:0]   pend_status_r, pend_status_nxt;
  logic                  pop_ok_r, pop_ok_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic [VAL_W-1:0]      out_value_r, out_value_nxt;

  logic [SW-1:0]         cap_wide;
  logic [CW-1:0]         cap_c;
  logic [CW:0]           fill_sum;
  logic                  full;
  logic [CW-1:0]         up_push_full;
  logic [CW-1:0]         lo_pop_full;
  logic [CW:0]           up_pop_full;

  logic                  ram_en, ram_we;
  logic [AW-1:0]         ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  // capacity saturates at the store depth
  assign cap_wide = SW'(cap_r);
  assign cap_c    = (cap_wide > SW'(DEPTH)) ? CW'(DEPTH) : cap_wide[CW-1:0];

  assign fill_sum     = {1'b0, lower_r} + {1'b0, upper_r};
  assign full         = fill_sum >= {1'b0, cap_c};
  assign up_push_full = cap_c - upper_r - CW'(1);
  assign lo_pop_full  = lower_r - CW'(1);

  // upper top entry, wrapped modulo the depth when it falls below zero
  always_comb begin
    up_pop_full = {1'b0, cap_c} - {1'b0, upper_r};
    if (upper_r > cap_c) begin
      up_pop_full = up_pop_full + (CW+1)'(DEPTH);
    end
  end

  always_comb begin
    ram_wdata            = '0;
    ram_wdata[MW-1:0]    = in_push_value[MW-1:0];
  end

  always_comb begin
    lower_nxt       = lower_r;
    upper_nxt       = upper_r;
    pend_status_nxt = pend_status_r;
    pop_ok_nxt      = pop_ok_r;
    ram_en          = 1'b0;
    ram_we          = 1'b0;
    ram_addr        = '0;
    if (cmd.accept) begin
      pend_status_nxt = ST_DONE;
      pop_ok_nxt      = 1'b0;
      case (in_operation)
        OP_PUSH: begin
          if (full) begin
            pend_status_nxt = ST_FULL;
          end else if (in_stack_select == SEL_LOWER) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = lower_r[AW-1:0];
            lower_nxt = lower_r + CW'(1);
          end else begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = up_push_full[AW-1:0];
            upper_nxt = upper_r + CW'(1);
          end
        end
        OP_POP: begin
          if (in_stack_select == SEL_LOWER) begin
            if (lower_r == '0) begin
              pend_status_nxt = ST_EMPTY;
            end else begin
              ram_en     = 1'b1;
              ram_addr   = lo_pop_full[AW-1:0];
              lower_nxt  = lo_pop_full;
              pop_ok_nxt = 1'b1;
            end
          end else begin
            if (upper_r == '0) begin
              pend_status_nxt = ST_EMPTY;
            end else begin
              ram_en     = 1'b1;
              ram_addr   = up_pop_full[AW-1:0];
              upper_nxt  = upper_r - CW'(1);
              pop_ok_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_value_nxt = '0;
    if (pop_ok_r) begin
      out_value_nxt[MW-1:0] = ram_rdata[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      lower_r <= '0;
      upper_r <= '0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pop_ok_r      <= pop_ok_nxt;
    if (cmd.load_out) begin
      out_status_r <= pend_status_r;
      out_value_r  <= out_value_nxt;
    end
  end

  dssm_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_status       = out_status_r;
  assign out_popped_value = out_value_r;

endmodule

// File: rtl/core/dual_stack_shared_memory_core.sv
// ============================================================================
// dual_stack_shared_memory_core - two stacks in one shared store
// Lower stack grows up from entry 0, upper stack grows down from the
// capacity in use; push/pop requests in, one status/value result out.
// ============================================================================
// Each request transaction is accepted in the idle state, in which the
// stack pointers move and the single store port is written (push) or read
// (pop); then, in the response state, the registered read data and the
// status are loaded into the output register once it is free. A new
// request is taken only after that load, back in the idle state. The
// result sits in an output register, and a new request is taken while it
// waits; only the pending result of that request then holds until the output
// frees up. A push is refused (status full) when both stacks together hold
// at least min(capacity, DEPTH) elements; a pop from an empty stack returns status
// empty and zero. The capacity register may only be written while idle; after
// reset the store content is unknown, and entries are read only once written.
// ============================================================================
module dual_stack_shared_memory_core import dssm_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dssm_in_if.sink   in_ch,
  dssm_out_if.source out_ch,
  dssm_cfg_if.sink  cfg_ch
);

  ctl_cmd_t cmd;

  // sequencer: accept, then deliver
  dssm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // pointers, capacity register, store and result register
  dssm_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_ch.operation),
    .in_stack_select  (in_ch.stack_select),
    .in_push_value    (in_ch.push_value),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_data         (cfg_ch.data),
    .out_status       (out_ch.status),
    .out_popped_value (out_ch.popped_value)
  );

  // only one request in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  // a pending result never overwrites an undelivered one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten before transaction completed");

  // refused transactions carry a zero value
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_DONE) |-> (out_ch.popped_value == '0))
    else $error("refused transaction with nonzero value");

  // status is one of done, full, empty
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == ST_DONE || out_ch.status == ST_FULL ||
                      out_ch.status == ST_EMPTY))
    else $error("illegal status code");

endmodule
